[design/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer: command codes,
// blank cell character, reset attribute and default screen geometry.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] RESET_ATTR = 8'h07;
	localparam logic [7:0] LF_CHAR    = 8'd10;
	localparam logic [7:0] CR_CHAR    = 8'd13;

	typedef enum logic [2:0] {
		CMD_PUT    = 3'd0,
		CMD_BKSP   = 3'd1,
		CMD_CLEAR  = 3'd2,
		CMD_SETCUR = 3'd3,
		CMD_READ   = 3'd4
	} cmd_t;

endpackage

[design/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console: COLUMNS x ROWS cells of {attribute, char} in
// one memory, a cursor, and a row-offset ring so that a scroll only blanks
// one physical row.
// ----------------------------------------------------------------------------
// Flow: an accepted word goes to ST_EXEC, then ST_DONE registers its result
//   once the output register is free. A scroll adds ST_SCROLL, one cell
//   blanked per cycle over one row; a clear adds ST_CLEAR, one cell per cycle
//   through the single write port. No new word is taken before the result is
//   loaded. Reset: cursor home, attribute 0x07; a clearing pass fills the
//   memory with blanks and holds in_stall high meanwhile.
module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [7:0]  char_code,
	input  logic [6:0]  column,
	input  logic [4:0]  row,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] cursor_pos,
	output logic [6:0]  cursor_col,
	output logic [4:0]  cursor_row,
	output logic [7:0]  read_char,
	output logic [7:0]  read_attr,
	output logic        scrolled
);

	import tcw_pkg::*;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int RS_W   = ROW_W + 1;
	localparam int CS_W   = COL_W + 1;
	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int LIN_W  = (ADDR_W > 11) ? ADDR_W : 11;
	localparam int CX_W   = (COL_W > 7) ? COL_W : 7;
	localparam int RX_W   = (ROW_W > 5) ? ROW_W : 5;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
	localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

	typedef enum logic [5:0] {
		ST_INIT   = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_EXEC   = 6'b000100,
		ST_CLEAR  = 6'b001000,
		ST_SCROLL = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] lrow,
			input logic [COL_W-1:0] col, input logic [ROW_W-1:0] top);
		logic [RS_W-1:0] sum;
		begin
			sum = {1'b0, lrow} + {1'b0, top};
			if (sum >= RS_W'(ROWS))
				sum = sum - RS_W'(ROWS);
			return ADDR_W'(ADDR_W'(sum[ROW_W-1:0]) * ADDR_W'(COLUMNS)) + ADDR_W'(col);
		end
	endfunction

	state_t            state_q;
	cmd_t              cmd_q;
	logic [7:0]        char_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  ccol_q;
	logic [ROW_W-1:0]  cline_q;
	logic [ROW_W-1:0]  top_q;
	logic [7:0]        attr_q;
	logic [ADDR_W-1:0] sweep_q;
	logic [ADDR_W-1:0] end_q;
	logic              scroll_q;

	logic [15:0]       mem_q [CELLS];
	logic [15:0]       rdata_q;

	logic              out_valid_q;
	logic [10:0]       cursor_pos_q;
	logic [6:0]        cursor_col_q;
	logic [4:0]        cursor_row_q;
	logic [7:0]        read_char_q;
	logic [7:0]        read_attr_q;
	logic              scrolled_q;

	logic              in_fire;
	logic              out_load;
	logic [CX_W-1:0]   col_ext;
	logic [RX_W-1:0]   row_ext;
	logic [COL_W-1:0]  col_clamp;
	logic [ROW_W-1:0]  row_clamp;
	logic              is_nl;
	logic [CS_W-1:0]   col_inc;
	logic              bs_home;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [15:0]       wdata;
	logic [ROW_W-1:0]  wr_lrow;
	logic [COL_W-1:0]  wr_col;
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] top_base;
	logic [LIN_W-1:0]  lin_pos;
	logic [CX_W-1:0]   ccol_ext;
	logic [RX_W-1:0]   cline_ext;

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	assign col_ext   = CX_W'(column);
	assign row_ext   = RX_W'(row);
	assign col_clamp = (col_ext > CX_W'(COLUMNS - 1)) ? LAST_COL : col_ext[COL_W-1:0];
	assign row_clamp = (row_ext > RX_W'(ROWS - 1)) ? LAST_ROW : row_ext[ROW_W-1:0];

	assign is_nl   = (char_q == LF_CHAR) || (char_q == CR_CHAR);
	assign col_inc = {1'b0, ccol_q} + CS_W'(1);
	assign bs_home = (ccol_q == '0) && (cline_q == '0);

	assign raddr    = cell_addr(row_q, col_q, top_q);
	assign top_base = ADDR_W'(ADDR_W'(top_q) * ADDR_W'(COLUMNS));

	assign lin_pos   = LIN_W'(LIN_W'(cline_q) * LIN_W'(COLUMNS)) + LIN_W'(ccol_q);
	assign ccol_ext  = CX_W'(ccol_q);
	assign cline_ext = RX_W'(cline_q);

	always_comb begin
		wr_lrow = cline_q;
		wr_col  = ccol_q;
		if (cmd_q == CMD_BKSP) begin
			if (ccol_q == '0) begin
				wr_lrow = cline_q - ROW_W'(1);
				wr_col  = LAST_COL;
			end else begin
				wr_col = ccol_q - COL_W'(1);
			end
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = sweep_q;
		wdata = {attr_q, BLANK_CHAR};
		unique case (state_q)
			ST_INIT: begin
				we    = 1'b1;
				wdata = {RESET_ATTR, BLANK_CHAR};
			end
			ST_CLEAR, ST_SCROLL: begin
				we = 1'b1;
			end
			ST_EXEC: begin
				waddr = cell_addr(wr_lrow, wr_col, top_q);
				if (cmd_q == CMD_PUT && !is_nl) begin
					we    = 1'b1;
					wdata = {attr_q, char_q};
				end else if (cmd_q == CMD_BKSP && !bs_home) begin
					we = 1'b1;
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (cfg_wr_en) begin
			attr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q  <= cmd_t'(command);
			char_q <= char_code;
			col_q  <= col_clamp;
			row_q  <= row_clamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			ccol_q   <= '0;
			cline_q  <= '0;
			top_q    <= '0;
			sweep_q  <= '0;
			end_q    <= '0;
			scroll_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					if (sweep_q == LAST_ADDR) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + ADDR_W'(1);
					end
				end
				ST_IDLE: begin
					scroll_q <= 1'b0;
					if (in_fire)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					unique case (cmd_q)
						CMD_PUT: begin
							if (is_nl || col_inc == CS_W'(COLUMNS)) begin
								ccol_q <= '0;
								if (cline_q == LAST_ROW) begin
									scroll_q <= 1'b1;
									sweep_q  <= top_base;
									end_q    <= top_base + ADDR_W'(COLUMNS - 1);
									top_q    <= (top_q == LAST_ROW) ? '0 : top_q + ROW_W'(1);
									state_q  <= ST_SCROLL;
								end else begin
									cline_q <= cline_q + ROW_W'(1);
									state_q <= ST_DONE;
								end
							end else begin
								ccol_q  <= col_inc[COL_W-1:0];
								state_q <= ST_DONE;
							end
						end
						CMD_BKSP: begin
							state_q <= ST_DONE;
							if (!bs_home) begin
								ccol_q  <= wr_col;
								cline_q <= wr_lrow;
							end
						end
						CMD_CLEAR: begin
							sweep_q <= '0;
							end_q   <= LAST_ADDR;
							state_q <= ST_CLEAR;
						end
						CMD_SETCUR: begin
							ccol_q  <= col_q;
							cline_q <= row_q;
							state_q <= ST_DONE;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_CLEAR, ST_SCROLL: begin
					sweep_q <= sweep_q + ADDR_W'(1);
					if (sweep_q == end_q)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cursor_pos_q <= lin_pos[10:0];
			cursor_col_q <= ccol_ext[6:0];
			cursor_row_q <= cline_ext[4:0];
			scrolled_q   <= scroll_q;
			if (cmd_q == CMD_READ) begin
				read_char_q <= rdata_q[7:0];
				read_attr_q <= rdata_q[15:8];
			end else begin
				read_char_q <= '0;
				read_attr_q <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign cursor_pos = cursor_pos_q;
	assign cursor_col = cursor_col_q;
	assign cursor_row = cursor_row_q;
	assign read_char  = read_char_q;
	assign read_attr  = read_attr_q;
	assign scrolled   = scrolled_q;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for text_console_writer. A clocked driver sends command words
// from a queue and a clocked monitor compares each result word, field by
// field, with a screen/cursor predictor kept inside the bench. Directed
// corner words come first, then random traffic under three gap patterns
// and several attribute settings.
// ----------------------------------------------------------------------------
module tb_top;

	import tcw_pkg::*;

	localparam int COLS   = COLUMNS_DEF;
	localparam int LINES  = ROWS_DEF;
	localparam int CELLS  = COLS * LINES;

	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

	typedef struct {
		bit         hold;
		logic [2:0] command;
		logic [7:0] char_code;
		logic [6:0] column;
		logic [4:0] row;
	} console_word_t;

	typedef struct {
		logic [10:0] cursor_pos;
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [7:0]  read_char;
		logic [7:0]  read_attr;
		logic        scrolled;
	} cursor_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = 8'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  command = CMD_PUT;
	logic [7:0]  char_code = 8'd0;
	logic [6:0]  column = 7'd0;
	logic [4:0]  row = 5'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [10:0] cursor_pos;
	logic [6:0]  cursor_col;
	logic [4:0]  cursor_row;
	logic [7:0]  read_char;
	logic [7:0]  read_attr;
	logic        scrolled;

	text_console_writer i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.char_code  (char_code),
		.column     (column),
		.row        (row),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cursor_pos (cursor_pos),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row),
		.read_char  (read_char),
		.read_attr  (read_attr),
		.scrolled   (scrolled)
	);

	// predicted console state
	logic [15:0] screen_model [CELLS];
	logic [7:0]  text_attr;
	int          cur_col;
	int          cur_line;

	console_word_t  word_q [$];
	cursor_report_t report_q [$];
	console_word_t  next_word;
	cursor_report_t seen_report;
	cursor_report_t want_report;
	logic           reports_drained = 1'b1;
	int             send_gap_pct = 0;
	int             recv_gap_pct = 0;
	int             errors = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic bit advance_line();
		bit wrapped;
		int i;
		wrapped = 1'b0;
		cur_line++;
		if (cur_line >= LINES) begin
			for (i = 0; i < COLS * (LINES - 1); i++)
				screen_model[i] = screen_model[i + COLS];
			for (i = 0; i < COLS; i++)
				screen_model[(LINES - 1) * COLS + i] = {text_attr, BLANK_CHAR};
			cur_line = LINES - 1;
			wrapped  = 1'b1;
		end
		cur_col = 0;
		return wrapped;
	endfunction

	function automatic cursor_report_t console_step(logic [2:0] cmd, logic [7:0] ch,
			logic [6:0] col, logic [4:0] rw);
		cursor_report_t rep;
		int c;
		int r;
		int i;
		c = (col > COLS - 1) ? COLS - 1 : int'(col);
		r = (rw > LINES - 1) ? LINES - 1 : int'(rw);
		rep.read_char = 8'd0;
		rep.read_attr = 8'd0;
		rep.scrolled  = 1'b0;
		case (cmd)
			CMD_PUT: begin
				if (ch == LF_CHAR || ch == CR_CHAR) begin
					rep.scrolled = advance_line();
				end else begin
					screen_model[cur_line * COLS + cur_col] = {text_attr, ch};
					cur_col++;
					if (cur_col >= COLS)
						rep.scrolled = advance_line();
				end
			end
			CMD_BKSP: begin
				if (cur_col == 0 && cur_line == 0) begin
				end else if (cur_col == 0) begin
					cur_line--;
					cur_col = COLS - 1;
					screen_model[cur_line * COLS + cur_col] = {text_attr, BLANK_CHAR};
				end else begin
					cur_col--;
					screen_model[cur_line * COLS + cur_col] = {text_attr, BLANK_CHAR};
				end
			end
			CMD_CLEAR: begin
				for (i = 0; i < CELLS; i++)
					screen_model[i] = {text_attr, BLANK_CHAR};
			end
			CMD_SETCUR: begin
				cur_col  = c;
				cur_line = r;
			end
			CMD_READ: begin
				rep.read_char = screen_model[r * COLS + c][7:0];
				rep.read_attr = screen_model[r * COLS + c][15:8];
			end
			default: begin
			end
		endcase
		rep.cursor_pos = 11'(cur_line * COLS + cur_col);
		rep.cursor_col = 7'(cur_col);
		rep.cursor_row = 5'(cur_line);
		return rep;
	endfunction

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (word_q.size() > 0 && word_q[0].hold && reports_drained && !in_valid)
					word_q.delete(0);
				if (word_q.size() > 0 && !word_q[0].hold &&
						$urandom_range(99) >= send_gap_pct) begin
					next_word = word_q.pop_front();
					command   <= next_word.command;
					char_code <= next_word.char_code;
					column    <= next_word.column;
					row       <= next_word.row;
					in_valid  <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and predictor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen_report.cursor_pos = cursor_pos;
				seen_report.cursor_col = cursor_col;
				seen_report.cursor_row = cursor_row;
				seen_report.read_char  = read_char;
				seen_report.read_attr  = read_attr;
				seen_report.scrolled   = scrolled;
				if (report_q.size() == 0) begin
					$error("unexpected result word, cursor_pos %0d", cursor_pos);
					errors++;
				end else begin
					want_report = report_q.pop_front();
					check_field("cursor_pos", int'(want_report.cursor_pos),
						int'(seen_report.cursor_pos));
					check_field("cursor_col", int'(want_report.cursor_col),
						int'(seen_report.cursor_col));
					check_field("cursor_row", int'(want_report.cursor_row),
						int'(seen_report.cursor_row));
					check_field("read_char", int'(want_report.read_char),
						int'(seen_report.read_char));
					check_field("read_attr", int'(want_report.read_attr),
						int'(seen_report.read_attr));
					check_field("scrolled", int'(want_report.scrolled),
						int'(seen_report.scrolled));
				end
			end
			if (in_valid && !in_stall)
				report_q.push_back(console_step(command, char_code, column, row));
			out_stall <= ($urandom_range(99) < recv_gap_pct);
		end
		reports_drained <= (report_q.size() == 0);
	end

	task automatic queue_word(logic [2:0] cmd, logic [7:0] ch, logic [6:0] col,
			logic [4:0] rw);
		console_word_t w;
		w.hold      = 1'b0;
		w.command   = cmd;
		w.char_code = ch;
		w.column    = col;
		w.row       = rw;
		word_q.push_back(w);
	endtask

	task automatic queue_hold();
		console_word_t w;
		w.hold      = 1'b1;
		w.command   = CMD_PUT;
		w.char_code = 8'd0;
		w.column    = 7'd0;
		w.row       = 5'd0;
		word_q.push_back(w);
	endtask

	task automatic queue_random_words(int count);
		int n;
		int pick;
		logic [2:0] cmd;
		logic [7:0] ch;
		logic [6:0] col;
		logic [4:0] rw;
		for (n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			ch   = 8'($urandom_range(255));
			col  = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) :
				7'($urandom_range(COLS - 1));
			rw   = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) :
				5'($urandom_range(LINES - 1));
			if (pick < 55) begin
				cmd = CMD_PUT;
				if ($urandom_range(9) == 0)
					ch = $urandom_range(1) ? LF_CHAR : CR_CHAR;
			end else if (pick < 67) begin
				cmd = CMD_BKSP;
			end else if (pick < 77) begin
				cmd = CMD_SETCUR;
			end else if (pick < 95) begin
				cmd = CMD_READ;
			end else if (pick < 96) begin
				cmd = CMD_CLEAR;
			end else begin
				cmd = 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
			end
			queue_word(cmd, ch, col, rw);
		end
	endtask

	task automatic settle();
		do @(negedge clk);
		while (word_q.size() != 0 || in_valid || !reports_drained);
	endtask

	task automatic write_attribute(logic [7:0] value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		text_attr = value;
		@(negedge clk);
	endtask

	initial begin
		int i;
		text_attr = RESET_ATTR;
		cur_col   = 0;
		cur_line  = 0;
		for (i = 0; i < CELLS; i++)
			screen_model[i] = {RESET_ATTR, BLANK_CHAR};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_gap_pct = 23;
		recv_gap_pct = 75;
		queue_word(CMD_READ, 8'h00, 7'd0, 5'd0);
		queue_word(CMD_PUT, 8'h41, 7'd0, 5'd0);
		queue_word(CMD_PUT, 8'hFF, 7'd127, 5'd31);
		queue_word(CMD_PUT, 8'h00, 7'd0, 5'd0);
		queue_word(CMD_READ, 8'hFF, 7'd1, 5'd0);
		queue_word(CMD_PUT, LF_CHAR, 7'd0, 5'd0);
		queue_word(CMD_PUT, CR_CHAR, 7'd0, 5'd0);
		queue_word(CMD_BKSP, 8'h00, 7'd0, 5'd0);
		queue_word(CMD_READ, 8'h00, 7'd79, 5'd1);
		queue_word(CMD_SETCUR, 8'h00, 7'd0, 5'd0);
		queue_word(CMD_BKSP, 8'h00, 7'd0, 5'd0);
		queue_word(CMD_SETCUR, 8'h00, 7'd127, 5'd31);
		queue_word(CMD_PUT, 8'h5A, 7'd0, 5'd0);
		queue_word(CMD_READ, 8'h00, 7'd79, 5'd23);
		queue_word(CMD_PUT, LF_CHAR, 7'd0, 5'd0);
		queue_word(CMD_READ, 8'h00, 7'd127, 5'd31);
		queue_word(CMD_SETCUR, 8'h00, 7'd78, 5'd3);
		queue_word(CMD_PUT, 8'h71, 7'd0, 5'd0);
		queue_word(CMD_PUT, 8'h72, 7'd0, 5'd0);
		queue_word(CMD_BKSP, 8'h00, 7'd0, 5'd0);
		queue_word(CMD_SPARE_FIRST, 8'hFF, 7'd127, 5'd31);
		queue_word(CMD_SPARE_LAST, 8'h00, 7'd0, 5'd0);
		queue_word(CMD_CLEAR, 8'h00, 7'd0, 5'd0);
		queue_word(CMD_READ, 8'h00, 7'd0, 5'd3);
		queue_hold();
		queue_word(CMD_READ, 8'h00, 7'd79, 5'd24);
		settle();

		write_attribute(8'h00);
		queue_random_words(200);
		queue_hold();
		queue_random_words(230);
		settle();

		send_gap_pct = 75;
		recv_gap_pct = 23;
		write_attribute(8'hFF);
		queue_random_words(430);
		settle();

		send_gap_pct = 0;
		recv_gap_pct = 0;
		write_attribute(8'($urandom_range(254, 1)));
		queue_random_words(430);
		settle();

		repeat (200) @(posedge clk);
		if (errors == 0 && report_q.size() == 0)
			$display("text_console_writer: match");
		else
			$display("text_console_writer: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("text_console_writer: mismatch");
		$finish;
	end

endmodule

[text_console_writer.f]
design/tcw_pkg.sv
design/text_console_writer.sv
verif/tb_top.sv
